// ----- hw/rtl/lsc_pkg.sv -----
// ============================================================================
// lsc_pkg: shared types and codes for the indexed list store
// Request action codes, result status codes, field widths and the control
// struct that the top level broadcasts to every storage cell.
// ============================================================================
package lsc_pkg;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 7;

    localparam int S_TDATA_W = 48;  // 43 payload bits rounded up to bytes
    localparam int M_TDATA_W = 48;  // 41 payload bits rounded up to bytes

    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_INS_POS   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DEL_POS   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Per-cycle command seen by every cell of the chain.
    typedef struct packed {
        logic ins;  // open a gap at pos and load the new value there
        logic del;  // close the gap at pos, cells above take their right side
        logic rd;   // the cell at pos drives its value onto the read bus
    } cell_ctl_t;

endpackage

// ----- hw/rtl/indexed_list_store.sv -----
// ============================================================================
// indexed_list_store: ordered list of signed 32-bit values in a cell chain
// Read, insert at front/back/position and delete at position, one request
// per cycle while results are drained, one result per request.
// ============================================================================
// The list lives in a row of CAPACITY cells, position 0 in cell 0. For each
// request the decoder checks the position against the current count, then
// all cells move at once, each taking its left neighbor to open a gap or
// its right neighbor to close one. A read picks the selected cell through
// a gated OR bus. Results sit in one output register, so a new request is
// taken in every cycle in which that register is empty or is being
// drained; sustained rate is one request per clock while the result side
// keeps draining. An insert into a full list returns status full and
// leaves the list as it was; out-of-range reads, deletes and inserts past
// the end return status range. Cell contents are not reset; only the count
// and the result valid flag are.
module indexed_list_store #(
    parameter int CAPACITY = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: action[2:0], position[10:3], value[42:11], zero[47:43]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsc_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: read_value[31:0], status[33:32], length[40:34], zero[47:41]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsc_pkg::M_TDATA_W-1:0] m_tdata
);
    import lsc_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);        // count width
    localparam int PW = (CW > POS_W) ? CW : POS_W;   // compare width

    // ---- request fields --------------------------------------------------
    logic [ACTION_W-1:0] req_action;
    logic [POS_W-1:0]    req_pos;
    logic [VALUE_W-1:0]  req_value;

    assign req_action = s_tdata[2:0];
    assign req_pos    = s_tdata[10:3];
    assign req_value  = s_tdata[42:11];

    logic accept;
    assign accept = s_tvalid && s_tready;

    // ---- count -----------------------------------------------------------
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // ---- decode ----------------------------------------------------------
    logic               pos_neg;
    logic [PW-1:0]      pos_u;
    logic [PW-1:0]      cnt_u;
    logic               full;
    logic               ins_req;
    logic               del_req;
    logic               rd_req;
    logic [PW-1:0]      op_pos;
    logic [STATUS_W-1:0] status;
    cell_ctl_t          ctl;

    assign pos_neg = req_pos[POS_W-1];
    assign pos_u   = PW'(req_pos[POS_W-2:0]);
    assign cnt_u   = PW'(count_reg);
    assign full    = (count_reg == CW'(CAPACITY));

    always_comb begin
        ins_req = 1'b0;
        del_req = 1'b0;
        rd_req  = 1'b0;
        op_pos  = pos_u;
        status  = ST_DONE;
        unique case (req_action)
            ACT_READ: begin
                if (pos_neg || (pos_u >= cnt_u)) begin
                    status = ST_RANGE;
                end else begin
                    rd_req = 1'b1;
                end
            end
            ACT_INS_FRONT: begin
                ins_req = 1'b1;
                op_pos  = '0;
            end
            ACT_INS_BACK: begin
                ins_req = 1'b1;
                op_pos  = cnt_u;
            end
            ACT_INS_POS: begin
                priority if (pos_neg) begin
                    ins_req = 1'b1;
                    op_pos  = '0;
                end else if (pos_u > cnt_u) begin
                    status = ST_RANGE;
                end else begin
                    ins_req = 1'b1;
                end
            end
            ACT_DEL_POS: begin
                if (pos_neg || (pos_u >= cnt_u)) begin
                    status = ST_RANGE;
                end else begin
                    del_req = 1'b1;
                end
            end
            default: begin
                // unknown action: change nothing, report done
            end
        endcase
        // range check wins over the full check; drop the insert when full
        if (ins_req && full) begin
            ins_req = 1'b0;
            status  = ST_FULL;
        end
    end

    // gate the insert and delete commands with the handshake; the read select is not gated
    assign ctl.ins = accept && ins_req;
    assign ctl.del = accept && del_req;
    assign ctl.rd  = rd_req;

    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.del) begin
            count_next = count_reg - CW'(1);
        end
    end

    // ---- cell chain ------------------------------------------------------
    logic [VALUE_W-1:0] cell_value [CAPACITY];
    logic [VALUE_W-1:0] cell_rd    [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_W-1:0] left_v;
        logic [VALUE_W-1:0] right_v;
        if (i == 0) begin : g_first
            assign left_v = req_value;
        end else begin : g_mid_l
            assign left_v = cell_value[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_v = cell_value[i];
        end else begin : g_mid_r
            assign right_v = cell_value[i+1];
        end
        lsc_cell #(
            .IDX (i),
            .PW  (PW)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .pos         (op_pos),
            .ins_value   (req_value),
            .left_value  (left_v),
            .right_value (right_v),
            .value_out   (cell_value[i]),
            .rd_out      (cell_rd[i])
        );
    end

    // OR the gated cell outputs; at most one cell is selected
    logic [VALUE_W-1:0] rd_bus;
    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    // ---- result register -------------------------------------------------
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [VALUE_W-1:0]  rd_value_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [LENGTH_W-1:0] length_reg;

    assign s_tready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the payload until the next accepted request
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_value_reg <= rd_bus;
            status_reg   <= status;
            length_reg   <= LENGTH_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, length_reg, status_reg, rd_value_reg};

endmodule

// ----- hw/rtl/lsc_cell.sv -----
// ============================================================================
// lsc_cell: one storage cell of the list chain
// Holds one list entry; takes the new value or its left neighbor on insert,
// its right neighbor on delete, and offers its value to the read bus when selected.
// ============================================================================
module lsc_cell #(
    parameter int IDX = 0,
    parameter int PW  = 8
) (
    input  logic                      aclk,
    input  lsc_pkg::cell_ctl_t        ctl,
    input  logic [PW-1:0]             pos,
    input  logic [lsc_pkg::VALUE_W-1:0] ins_value,
    input  logic [lsc_pkg::VALUE_W-1:0] left_value,
    input  logic [lsc_pkg::VALUE_W-1:0] right_value,
    output logic [lsc_pkg::VALUE_W-1:0] value_out,
    output logic [lsc_pkg::VALUE_W-1:0] rd_out
);
    import lsc_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctl.ins) begin
            if (MY_IDX == pos) begin
                value_next = ins_value;
            end else if (MY_IDX > pos) begin
                value_next = left_value;
            end
        end else if (ctl.del && (MY_IDX >= pos)) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_out = value_reg;
    assign rd_out    = (ctl.rd && (MY_IDX == pos)) ? value_reg : '0;

endmodule

// ----- hw/rtl/lsc_checker.sv -----
// ============================================================================
// lsc_checker: port-level checks for the indexed list store
// Watches the request and result channels of the top level; bound below.
// ============================================================================
module lsc_checker #(
    parameter int CAPACITY = 64
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [lsc_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lsc_pkg::M_TDATA_W-1:0] m_tdata
);
    import lsc_pkg::*;

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // an accepted request shows its result on the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request produced no result");

    // with no result pending the block takes a request
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request side stalled with empty result register");

    // a failed request carries a zero read value
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] != ST_DONE) |-> (m_tdata[31:0] == '0))
        else $error("non-zero read value on failed request");

    // a full status reports a full list
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] == ST_FULL) |-> (m_tdata[40:34] == 7'(CAPACITY)))
        else $error("full status with wrong length");

endmodule

bind indexed_list_store lsc_checker #(.CAPACITY(CAPACITY)) u_lsc_checker (.*);

// ----- tb/sv/list_store_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// list_store_checker: in-order result scoreboard for the indexed list store
// Watches the request and result streams, keeps its own copy of the list,
// predicts one result per accepted request and compares results in order.
// ============================================================================
module list_store_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // s_tdata: action[2:0], position[10:3], value[42:11], zero[47:43]
    input  logic [lsc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: read_value[31:0], status[33:32], length[40:34], zero[47:41]
    input  logic [lsc_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending,
    output int                            list_len,
    output int                            req_cnt,
    output int                            done_cnt,
    output int                            range_cnt,
    output int                            full_cnt,
    output int                            peak_len
);
    import lsc_pkg::*;

    localparam int POS_LSB    = ACTION_W;
    localparam int VALUE_LSB  = ACTION_W + POS_W;
    localparam int STATUS_LSB = VALUE_W;
    localparam int LENGTH_LSB = VALUE_W + STATUS_W;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
        logic [LENGTH_W-1:0] length;
    } list_result_t;

    logic [VALUE_W-1:0] cells [CAPACITY];
    int                 item_count;
    int                 result_idx;
    list_result_t       expected_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        list_len   = 0;
        req_cnt    = 0;
        done_cnt   = 0;
        range_cnt  = 0;
        full_cnt   = 0;
        peak_len   = 0;
        result_idx = 0;
        item_count = 0;
    end

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] result %0d %s: got %0h expected %0h",
                     $realtime, result_idx, what, got, want);
        fail_count++;
    endtask

    // Apply one request to the shadow list and return the result it causes.
    task automatic apply_request(input logic [ACTION_W-1:0] act,
                                 input logic [POS_W-1:0] pos,
                                 input logic [VALUE_W-1:0] val,
                                 output list_result_t res);
        bit neg;
        bit do_ins;
        int at;
        int p;
        neg    = pos[POS_W-1];
        p      = int'(pos);
        do_ins = 1'b0;
        at     = 0;
        res.read_value = '0;
        res.status     = ST_DONE;
        case (act)
            ACT_READ: begin
                if (neg || p >= item_count) res.status = ST_RANGE;
                else res.read_value = cells[p];
            end
            ACT_INS_FRONT: begin
                do_ins = 1'b1;
                at     = 0;
            end
            ACT_INS_BACK: begin
                do_ins = 1'b1;
                at     = item_count;
            end
            ACT_INS_POS: begin
                if (neg) begin
                    do_ins = 1'b1;
                    at     = 0;
                end else if (p > item_count) begin
                    res.status = ST_RANGE;
                end else begin
                    do_ins = 1'b1;
                    at     = p;
                end
            end
            ACT_DEL_POS: begin
                if (neg || p >= item_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int k = p; k < item_count - 1; k++) cells[k] = cells[k + 1];
                    item_count--;
                end
            end
            default: ;
        endcase
        // range check wins over the full check
        if (do_ins) begin
            if (item_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                for (int k = item_count; k > at; k--) cells[k] = cells[k - 1];
                cells[at] = val;
                item_count++;
            end
        end
        res.length = LENGTH_W'(item_count);
    endtask

    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (!aresetn) begin
            item_count = 0;
            expected_q.delete();
            pending  <= 0;
            list_len <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.read_value = m_tdata[VALUE_W-1:0];
                got.status     = m_tdata[STATUS_LSB +: STATUS_W];
                got.length     = m_tdata[LENGTH_LSB +: LENGTH_W];
                if (expected_q.size() == 0) begin
                    report_mismatch("arrived with no request waiting", got.read_value, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", got.read_value, want.read_value);
                    if (got.status !== want.status)
                        report_mismatch("status", VALUE_W'(got.status),
                                        VALUE_W'(want.status));
                    if (got.length !== want.length)
                        report_mismatch("length", VALUE_W'(got.length),
                                        VALUE_W'(want.length));
                end
                result_idx++;
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tdata[ACTION_W-1:0], s_tdata[POS_LSB +: POS_W],
                              s_tdata[VALUE_LSB +: VALUE_W], want);
                expected_q.push_back(want);
                req_cnt++;
                case (want.status)
                    ST_RANGE: range_cnt++;
                    ST_FULL:  full_cnt++;
                    default:  done_cnt++;
                endcase
                if (item_count > peak_len) peak_len = item_count;
            end
            pending  <= expected_q.size();
            list_len <= item_count;
        end
    end

endmodule

// ----- tb/sv/tb_indexed_list_store.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_indexed_list_store: stimulus and verdict for the indexed list store
// Drives a short directed run over every action and corner, then random
// grow, shrink and mixed runs with random idling on both streams, a long
// result back-pressure stretch and a full drain pause. Checking is done by
// list_store_checker, which hands back its failure count.
// ============================================================================
module tb_indexed_list_store;
    import lsc_pkg::*;

    localparam int CAPACITY         = 64;
    localparam int TOTAL_ITEMS      = 1150;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int SEG_MAX_ITEMS    = 300;
    localparam int MIXED_SEG_ITEMS  = 60;
    localparam int BOUND_HITS       = 12;

    // action codes 5..7 are unused by the block and must change nothing
    localparam logic [ACTION_W-1:0] ACT_RSVD_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_HI = 3'd7;

    typedef enum int {
        MODE_GROW,
        MODE_MIXED,
        MODE_SHRINK
    } list_mode_e;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int list_len;
    int req_cnt;
    int done_cnt;
    int range_cnt;
    int full_cnt;
    int peak_len;
    int sent_cnt = 0;

    // shared between the request source and the result sink
    bit idle_off  = 1'b0;
    bit long_hold = 1'b0;

    always #5 aclk = ~aclk;

    indexed_list_store #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    list_store_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending),
        .list_len  (list_len),
        .req_cnt   (req_cnt),
        .done_cnt  (done_cnt),
        .range_cnt (range_cnt),
        .full_cnt  (full_cnt),
        .peak_len  (peak_len)
    );

    // Offer one request after a random gap and hold it until it is taken.
    // A zero gap keeps tvalid high, so back-to-back requests get one update.
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] val);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {{(S_TDATA_W - ACTION_W - POS_W - VALUE_W){1'b0}}, val, pos, act};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_cnt++;
    endtask

    // Hold off new requests until every expected result has come back or DRAIN_LIMIT is reached.
    task automatic wait_for_drain();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
    endtask

    // Corners: empty list, extreme values and positions, each insert form,
    // range checks on both ends, and the unused action codes.
    task automatic run_directed();
        send_request(ACT_READ,      8'd0,   32'h0000_0000);  // read on empty list
        send_request(ACT_DEL_POS,   8'd0,   32'h0000_0000);  // delete on empty list
        send_request(ACT_INS_POS,   8'd1,   32'h1111_1111);  // past the end: ignored
        send_request(ACT_INS_POS,   8'd0,   32'h7FFF_FFFF);  // at count: append
        send_request(ACT_INS_FRONT, 8'd0,   32'h8000_0000);
        send_request(ACT_INS_BACK,  8'd0,   32'hFFFF_FFFF);
        send_request(ACT_INS_POS,   8'h80,  32'h0000_0000);  // most negative: front
        send_request(ACT_INS_POS,   8'hFF,  32'h1234_5678);  // minus one: front
        send_request(ACT_INS_POS,   8'd5,   32'h0000_0001);  // at count: append
        send_request(ACT_INS_POS,   8'd3,   32'hA5A5_A5A5);  // middle
        send_request(ACT_READ,      8'd0,   32'hFFFF_FFFF);
        send_request(ACT_READ,      8'd6,   32'h0000_0000);  // last entry
        send_request(ACT_READ,      8'd7,   32'h0000_0000);  // one past the end
        send_request(ACT_READ,      8'hFF,  32'h0000_0000);  // negative
        send_request(ACT_READ,      8'h7F,  32'h0000_0000);  // largest positive
        send_request(ACT_DEL_POS,   8'h80,  32'h0000_0000);  // negative
        send_request(ACT_DEL_POS,   8'd7,   32'h0000_0000);  // one past the end
        send_request(ACT_DEL_POS,   8'd3,   32'h0000_0000);
        send_request(ACT_DEL_POS,   8'd0,   32'h0000_0000);
        send_request(ACT_DEL_POS,   8'd4,   32'h0000_0000);  // last entry
        send_request(ACT_RSVD_LO,     8'd0,  32'hFFFF_FFFF);
        send_request(ACTION_W'(ACT_RSVD_LO + 1), 8'h7F, 32'h5555_5555);
        send_request(ACT_RSVD_HI,     8'hFF, 32'hAAAA_AAAA);
        send_request(ACT_READ,      8'd2,   32'h0000_0000);
    endtask

    // Draw one request biased by the run mode; positions cluster around the
    // live part of the list, with some on the boundaries and some anywhere.
    task automatic send_random(input list_mode_e mode);
        int len;
        int roll;
        int ins_pct;
        int del_pct;
        int rd_pct;
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  val;
        len = list_len;
        case (mode)
            MODE_GROW: begin
                ins_pct = 80; del_pct = 7;  rd_pct = 10;
            end
            MODE_SHRINK: begin
                ins_pct = 12; del_pct = 70; rd_pct = 15;
            end
            default: begin
                ins_pct = 40; del_pct = 30; rd_pct = 27;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
            case ($urandom_range(0, 2))
                0:       act = ACT_INS_FRONT;
                1:       act = ACT_INS_BACK;
                default: act = ACT_INS_POS;
            endcase
        end else if (roll < ins_pct + del_pct) begin
            act = ACT_DEL_POS;
        end else if (roll < ins_pct + del_pct + rd_pct) begin
            act = ACT_READ;
        end else begin
            act = ACTION_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
        end
        case ($urandom_range(0, 9))
            0:       pos = POS_W'($urandom);
            1:       pos = {1'b1, 7'($urandom)};
            2:       pos = POS_W'(len);
            3:       pos = POS_W'(len + 1);
            default: pos = POS_W'($urandom_range(0, (len > 0) ? len - 1 : 0));
        endcase
        val = $urandom;
        send_request(act, pos, val);
    endtask

    // Result sink: stall a random number of cycles per result, or a long
    // stretch when asked, then take one result.
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                stall     = LONG_HOLD_CYCLES;
                long_hold = 1'b0;
            end else begin
                stall = idle_off ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int         seg;
        int         n;
        int         bound_hits;
        list_mode_e mode;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        // Cycle grow, mixed and shrink runs. Grow and shrink runs keep going
        // until they have pressed against the full or empty list a while.
        seg = 0;
        while (sent_cnt < TOTAL_ITEMS) begin
            mode     = list_mode_e'(seg % 3);
            idle_off = (seg % 4 == 1);
            // hold the result side off while requests keep coming
            if (seg == 1 || seg == 5) long_hold = 1'b1;
            // stop the request side until everything has come back
            if (seg == 3 || seg == 7) wait_for_drain();
            bound_hits = 0;
            for (n = 0; n < SEG_MAX_ITEMS && sent_cnt < TOTAL_ITEMS; n++) begin
                send_random(mode);
                if ((mode == MODE_GROW && list_len == CAPACITY) ||
                    (mode == MODE_SHRINK && list_len == 0))
                    bound_hits++;
                if (mode == MODE_MIXED ? (n >= MIXED_SEG_ITEMS - 1) : (bound_hits >= BOUND_HITS))
                    break;
            end
            seg++;
        end
        s_tvalid <= 1'b0;
        idle_off = 1'b0;

        wait_for_drain();
        repeat (4) @(posedge aclk);

        $display("Ran %0d requests over %0d random runs: %0d done, %0d out of range, %0d dropped",
                 req_cnt, seg, done_cnt, range_cnt, full_cnt);
        $display("List reached a peak length of %0d of %0d entries", peak_len, CAPACITY);
        if (pending != 0)
            $display("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("indexed_list_store verification clean");
        end else begin
            $display("indexed_list_store verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #(64'd2_000_000);
        $display("Timed out with %0d requests sent and %0d results pending", sent_cnt, pending);
        $display("indexed_list_store verification failed");
        $finish;
    end

endmodule
